### design/salru_pkg.sv
// shared types, constants and helpers of the lru cache tag store
package salru_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 32;

  localparam int STAMP_W  = 32;
  localparam int CNT_W    = 32;
  localparam int SET_W    = MAX_SET_BITS;
  localparam int NUM_SETS = 2 ** MAX_SET_BITS;
  localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W     = $clog2(MAX_WAYS + 1);
  localparam int NPAIR    = (MAX_WAYS + 1) / 2;
  localparam int NP2      = 2 ** $clog2(NPAIR);

  localparam int SET_BITS_W  = 3;
  localparam int WAYS_W      = 4;
  localparam int OFFSET_W    = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 3'd4;
  localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;
  localparam logic [OFFSET_W-1:0]   OFFSET_RST   = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS = 2'd0,
    REG_WAYS     = 2'd1,
    REG_OFFSET   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [ADDR_WIDTH-1:0] access_address;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             extra_hit;
    logic [2:0]       way_used;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } res_t;

  // one way of a set as it sits in the tag ram
  typedef struct packed {
    logic                  valid;
    logic [ADDR_WIDTH-1:0] line;
    logic [STAMP_W-1:0]    stamp;
  } entry_t;

  typedef entry_t [MAX_WAYS-1:0] row_t;

  // replacement candidate
  typedef struct packed {
    logic               ok;
    logic [WAY_W-1:0]   way;
    logic [STAMP_W-1:0] stamp;
  } cand_t;

  typedef cand_t [NP2-1:0] cand_vec_t;

  // lookup result handed from the match stage to the write stage
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    cand_vec_t        pairs;
  } match_t;

  // left operand always has the lower way index, so ties keep it
  function automatic cand_t cand_pick(cand_t a, cand_t b);
    return (b.ok && (!a.ok || (b.stamp < a.stamp))) ? b : a;
  endfunction

  function automatic cand_t cand_tree(cand_vec_t v);
    cand_vec_t t;
    t = v;
    for (int s = 1; s < NP2; s = s * 2) begin
      for (int i = 0; i < NP2; i = i + 2 * s) begin
        t[i] = cand_pick(t[i], t[i + s]);
      end
    end
    return t[0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, v} + (CNT_W + 1)'(inc);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

### design/salru_ram.sv
// generic single write port ram with registered read
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/salru_match.sv
// tag compare over one set and first level of the lru victim tree
module salru_match (
  input  salru_pkg::row_t                 row_i,
  input  logic [salru_pkg::ADDR_WIDTH-1:0] line_i,
  input  logic [salru_pkg::WC_W-1:0]       ways_i,
  output salru_pkg::match_t               match_o
);
  import salru_pkg::*;

  logic [MAX_WAYS-1:0] in_use;
  cand_t               a_c;
  cand_t               b_c;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (w < 32'(ways_i));
    end
  end

  always_comb begin
    // first matching way wins
    match_o.hit     = 1'b0;
    match_o.hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && row_i[w].valid && (row_i[w].line == line_i)) begin
        match_o.hit     = 1'b1;
        match_o.hit_way = WAY_W'(w);
      end
    end
    a_c = '0;
    b_c = '0;
    match_o.pairs = '0;
    for (int k = 0; k < NPAIR; k++) begin
      a_c.ok    = in_use[2 * k];
      a_c.way   = WAY_W'(2 * k);
      a_c.stamp = row_i[2 * k].stamp;
      b_c       = '0;
      if (2 * k + 1 < MAX_WAYS) begin
        b_c.ok    = in_use[2 * k + 1];
        b_c.way   = WAY_W'(2 * k + 1);
        b_c.stamp = row_i[2 * k + 1].stamp;
      end
      match_o.pairs[k] = cand_pick(a_c, b_c);
    end
  end

endmodule

### design/set_assoc_lru_cache_tag_model_unit.sv
// top level of the set-associative lru cache tag store
//
// usage
//   cfg port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the clock
//   edge (0 set_bits, 1 ways_in_use, 2 offset_bits, other indexes ignored);
//   write only while the block is idle
//   command: an item (opcode, byte address) is taken at an edge with start_i
//   high and busy_o low
//   result: done_o is high for exactly one cycle with result_o; the receiver
//   cannot stall, so nothing here waits on the output side
// timing
//   each item reads its set row from the tag ram (registered), compares all
//   ways and reduces the first lru tree level, then finishes the victim
//   tree and writes the row back
//   done_o and result_o are registered from the write stage
//   during the write-back cycle busy_o is low and the next item is taken,
//   so the next item overlaps the write-back of the previous one
//   the row forward register covers a read of the set being written
// reset
//   after rst_ni the tag ram is swept to zero, one set row per cycle, over
//   all 2^MAX_SET_BITS = 64 set rows with busy_o high; config writes still work
module set_assoc_lru_cache_tag_model_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [salru_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [salru_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          start_i,
  input  salru_pkg::cmd_t               cmd_i,
  output logic                          busy_o,
  output logic                          done_o,
  output salru_pkg::res_t               result_o
);
  import salru_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  state_e st_q, st_d;

  // config registers
  logic [SET_BITS_W-1:0] set_bits_q;
  logic [WAYS_W-1:0]     ways_q;
  logic [OFFSET_W-1:0]   offset_q;

  // clearing sweep
  logic [SET_W-1:0] clr_q;

  // item held across look and write
  logic                  mod_q;
  logic [ADDR_WIDTH-1:0] line_q;
  logic [SET_W-1:0]      set_q;
  logic [WC_W-1:0]       ways_eff_q;
  logic                  fwd_q;
  row_t                  row_q;
  row_t                  wrow_q;
  match_t                match_q;

  logic [STAMP_W-1:0] clock_q;
  logic [CNT_W-1:0]   hit_q;
  logic [CNT_W-1:0]   miss_q;
  logic [CNT_W-1:0]   evict_q;

  logic done_q;
  res_t res_q;

  // decode of the incoming command against current geometry
  logic                  accept;
  logic [SB_W-1:0]       sb_eff;
  logic [WC_W-1:0]       ways_eff;
  logic [ADDR_WIDTH-1:0] line_new;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [SET_W-1:0]      set_new;

  assign busy_o = (st_q == ST_CLEAR) || (st_q == ST_LOOK);
  assign accept = start_i && !busy_o;

  always_comb begin
    sb_eff = (32'(set_bits_q) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits_q);
    if (ways_q == '0) begin
      ways_eff = WC_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_q);
    end
    line_new = cmd_i.access_address & ({ADDR_WIDTH{1'b1}} << offset_q);
    shifted  = cmd_i.access_address >> offset_q;
    set_new  = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
  end

  // tag ram: one row per set, all ways side by side
  logic                   ram_we;
  logic [SET_W-1:0]       ram_waddr;
  logic [$bits(row_t)-1:0] ram_wdata;
  logic [$bits(row_t)-1:0] ram_rdata;

  salru_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NUM_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (set_new),
    .rdata_o (ram_rdata)
  );

  // look stage: pick forwarded row when the previous item wrote this set
  row_t   look_row;
  match_t look_match;

  assign look_row = fwd_q ? wrow_q : row_t'(ram_rdata);

  salru_match u_match (
    .row_i   (look_row),
    .line_i  (line_q),
    .ways_i  (ways_eff_q),
    .match_o (look_match)
  );

  // write stage: rest of the lru tree, row update, totals
  cand_t            victim;
  logic [WAY_W-1:0] way_sel;
  logic             evict;
  row_t             new_row;
  logic [1:0]       hit_inc;
  logic [CNT_W-1:0] hit_new;
  logic [CNT_W-1:0] miss_new;
  logic [CNT_W-1:0] evict_new;
  logic [31:0]      way_ext;

  always_comb begin
    victim   = cand_tree(match_q.pairs);
    way_sel  = match_q.hit ? match_q.hit_way : victim.way;
    evict    = !match_q.hit && row_q[victim.way].valid;
    new_row  = row_q;
    new_row[way_sel].valid = 1'b1;
    new_row[way_sel].line  = line_q;
    new_row[way_sel].stamp = clock_q;
    hit_inc   = 2'(match_q.hit) + 2'(mod_q);
    hit_new   = sat_add(hit_q, hit_inc);
    miss_new  = sat_add(miss_q, 2'(!match_q.hit));
    evict_new = sat_add(evict_q, 2'(evict));
    way_ext   = 32'(way_sel);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = new_row;
    if (st_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (st_q == ST_WRITE) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: begin
        if (&clr_q) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          st_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        st_d = ST_WRITE;
      end
      ST_WRITE: begin
        st_d = accept ? ST_LOOK : ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_CLEAR;
      clr_q      <= '0;
      set_bits_q <= SET_BITS_RST;
      ways_q     <= WAYS_RST;
      offset_q   <= OFFSET_RST;
      clock_q    <= '0;
      hit_q      <= '0;
      miss_q     <= '0;
      evict_q    <= '0;
      done_q     <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == ST_WRITE);
      if (st_q == ST_CLEAR) begin
        clr_q <= clr_q + SET_W'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SET_BITS: set_bits_q <= cfg_wdata_i[SET_BITS_W-1:0];
          REG_WAYS:     ways_q     <= cfg_wdata_i[WAYS_W-1:0];
          REG_OFFSET:   offset_q   <= cfg_wdata_i[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        fwd_q <= (st_q == ST_WRITE) && (set_new == set_q);
      end
      if (st_q == ST_LOOK) begin
        clock_q <= (&clock_q) ? clock_q : clock_q + STAMP_W'(1);
      end
      if (st_q == ST_WRITE) begin
        hit_q   <= hit_new;
        miss_q  <= miss_new;
        evict_q <= evict_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mod_q      <= (cmd_i.opcode == OP_MODIFY);
      line_q     <= line_new;
      set_q      <= set_new;
      ways_eff_q <= ways_eff;
    end
    if (st_q == ST_LOOK) begin
      row_q   <= look_row;
      match_q <= look_match;
    end
    if (st_q == ST_WRITE) begin
      wrow_q            <= new_row;
      res_q.outcome     <= match_q.hit ? OUT_HIT : (evict ? OUT_EVICT : OUT_FILL);
      res_q.extra_hit   <= mod_q;
      res_q.way_used    <= way_ext[2:0];
      res_q.hit_total   <= hit_new;
      res_q.miss_total  <= miss_new;
      res_q.evict_total <= evict_new;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
